[rtl/lgbs_pkg.sv]
// shared types, constants and helper functions for the led group blink sequencer
// no dependencies

package lgbs_pkg;

   localparam int LED_SLOTS    = 4;
   localparam int NUM_CHANNELS = 5;
   localparam int LED_IDX_W    = $clog2(LED_SLOTS);
   localparam int CNT_W        = 3;
   localparam int CHAN_IDX_W   = 3;
   localparam int TICK_W       = 16;

   localparam logic [7:0] CTRL_REG     = 8'h10;
   localparam logic [7:0] CTRL_DEFAULT = 8'h60;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_POWER = 1'b1;

   typedef enum logic [1:0] {
      MODE_LEVEL = 2'd0,
      MODE_BLINK = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CFG_MASK_0    = 3'd0,
      CFG_MASK_1    = 3'd1,
      CFG_MASK_2    = 3'd2,
      CFG_MASK_3    = 3'd3,
      CFG_LED_COUNT = 3'd4,
      CFG_ON_TICKS  = 3'd5,
      CFG_OFF_TICKS = 3'd6
   } cfg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_PLAN,
      S_PWR,
      S_CHAN,
      S_CTRL
   } state_type;

   typedef logic [NUM_CHANNELS-1:0] chan_mask_type;

   typedef struct packed {
      chan_mask_type [LED_SLOTS-1:0] mask;
      logic [CNT_W-1:0]              led_count;
      logic [TICK_W-1:0]             on_ticks;
      logic [TICK_W-1:0]             off_ticks;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] addr;
      logic [7:0] data;
      logic       power_on;
      logic       last;
   } emit_type;

   function automatic logic [7:0] chan_addr(input logic [CHAN_IDX_W-1:0] k);
      logic [7:0] a;
      unique case (k)
         3'd0:    a = 8'hA0;
         3'd1:    a = 8'h30;
         3'd2:    a = 8'h40;
         3'd3:    a = 8'h50;
         3'd4:    a = 8'h60;
         default: a = 8'h00;
      endcase
      return a;
   endfunction

   function automatic logic [CHAN_IDX_W-1:0] lowest_set(input chan_mask_type m);
      logic [CHAN_IDX_W-1:0] r;
      r = '0;
      for (int j = NUM_CHANNELS - 1; j >= 0; j--) begin
         if (m[j]) begin
            r = CHAN_IDX_W'(j);
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] ctrl_bits(input chan_mask_type m);
      return {{(8 - NUM_CHANNELS){1'b0}}, m};
   endfunction

endpackage

[rtl/lgbs_csr.sv]
// configuration registers: channel masks, led count, blink on and off times
// depends on lgbs_pkg

module lgbs_csr
   import lgbs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [TICK_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CFG_MASK_0, CFG_MASK_1, CFG_MASK_2, CFG_MASK_3: begin
               cfg_in.mask[csr_addr[LED_IDX_W-1:0]] = csr_wdata[NUM_CHANNELS-1:0];
            end
            CFG_LED_COUNT: cfg_in.led_count = csr_wdata[CNT_W-1:0];
            CFG_ON_TICKS:  cfg_in.on_ticks  = csr_wdata;
            CFG_OFF_TICKS: cfg_in.off_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LED_SLOTS; j++) begin
            cfg_ff.mask[j] <= (j < 4) ? NUM_CHANNELS'(1 << j) : '0;
         end
         cfg_ff.led_count <= CNT_W'(4);
         cfg_ff.on_ticks  <= TICK_W'(500);
         cfg_ff.off_ticks <= TICK_W'(500);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lgbs_obuf.sv]
// output register between the sequencer and the result stream
// depends on lgbs_pkg

module lgbs_obuf
   import lgbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  emit_type    emit,
   output logic        emit_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   logic     full_ff, full_in;
   emit_type beat_ff, beat_in;

   always_comb begin
      emit_ready = !full_ff || rsp_tready;
      full_in    = full_ff && !rsp_tready;
      beat_in    = beat_ff;
      if (emit.valid && emit_ready) begin
         full_in = 1'b1;
         beat_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      beat_ff <= beat_in;
   end

   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = {7'b0, beat_ff.power_on, beat_ff.data, beat_ff.addr};
   assign rsp_tuser  = beat_ff.kind;
   assign rsp_tlast  = beat_ff.last;

endmodule

[rtl/lgbs_core.sv]
// sequencer: led state, power decision, blink timer, and one chip action per beat
// depends on lgbs_pkg

module lgbs_core
   import lgbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   output emit_type    emit,
   input  logic        emit_ready
);

   state_type state_ff, state_in;

   logic [1:0]           mode_ff, mode_in;
   logic [LED_IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]           lvl_ff, lvl_in;
   logic                 want_ff, want_in;

   logic [LED_SLOTS-1:0][7:0] level_ff, level_in;
   logic [LED_SLOTS-1:0][7:0] cached_ff, cached_in;
   logic [LED_SLOTS-1:0]      cvalid_ff, cvalid_in;
   logic [LED_SLOTS-1:0]      blink_ff, blink_in;
   logic                      any_blink_ff, any_blink_in;
   logic                      phase_ff, phase_in;
   logic [7:0]                shadow_ff, shadow_in;
   logic                      powered_ff, powered_in;
   logic [TICK_W-1:0]         timer_ff, timer_in;

   chan_mask_type chan_rem_ff, chan_rem_in;
   logic          do_ctrl_ff, do_ctrl_in;
   logic [7:0]    ctrl_val_ff, ctrl_val_in;

   logic [CNT_W-1:0]      used;
   logic [LED_SLOTS-1:0]  use_mask;
   logic [LED_SLOTS-1:0]  lit;
   logic                  in_use;
   logic                  others_blink;
   logic [7:0]            cur_lvl;
   chan_mask_type         cur_mask;
   logic                  need;
   logic                  pwr_up;
   logic                  pwr_down;
   logic [7:0]            eff_shadow;
   logic                  do_chan;
   logic [7:0]            ctl_val;
   logic                  do_ctrl;
   logic [7:0]            fire_ctl;
   logic [TICK_W-1:0]     reload;
   logic [CHAN_IDX_W-1:0] chan_k;
   chan_mask_type         rem_after;

   always_comb begin
      used   = (cfg.led_count > CNT_W'(LED_SLOTS)) ? CNT_W'(LED_SLOTS) : cfg.led_count;
      in_use = {{(CNT_W - LED_IDX_W){1'b0}}, idx_ff} < used;
      for (int j = 0; j < LED_SLOTS; j++) begin
         use_mask[j] = CNT_W'(j) < used;
         lit[j]      = level_ff[j] != 8'd0;
      end
      others_blink = 1'b0;
      for (int j = 0; j < LED_SLOTS; j++) begin
         if (use_mask[j] && blink_ff[j] && (LED_IDX_W'(j) != idx_ff)) begin
            others_blink = 1'b1;
         end
      end
      cur_lvl  = level_ff[idx_ff];
      cur_mask = cfg.mask[idx_ff];

      // power and write plan for the addressed led
      need       = |(lit & use_mask);
      pwr_up     = need && !powered_ff;
      pwr_down   = !need && powered_ff;
      eff_shadow = pwr_up ? CTRL_DEFAULT : shadow_ff;
      do_chan    = need && (cur_lvl != 8'd0) && (cur_mask != '0)
                   && (!cvalid_ff[idx_ff] || (cached_ff[idx_ff] != cur_lvl));
      ctl_val    = eff_shadow & ~ctrl_bits(cur_mask);
      if (cur_lvl != 8'd0) begin
         ctl_val = ctl_val | ctrl_bits(cur_mask);
      end
      do_ctrl = need && (ctl_val != eff_shadow) && !blink_ff[idx_ff];

      // blink toggle value
      fire_ctl = shadow_ff;
      for (int j = 0; j < LED_SLOTS; j++) begin
         if (use_mask[j] && blink_ff[j]) begin
            fire_ctl = fire_ctl & ~ctrl_bits(cfg.mask[j]);
            if (phase_ff) begin
               fire_ctl = fire_ctl | ctrl_bits(cfg.mask[j]);
            end
         end
      end
      reload = phase_ff ? cfg.on_ticks : cfg.off_ticks;

      chan_k    = lowest_set(chan_rem_ff);
      rem_after = chan_rem_ff & ~(NUM_CHANNELS'(1) << chan_k);
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      lvl_in       = lvl_ff;
      want_in      = want_ff;
      level_in     = level_ff;
      cached_in    = cached_ff;
      cvalid_in    = cvalid_ff;
      blink_in     = blink_ff;
      any_blink_in = any_blink_ff;
      phase_in     = phase_ff;
      shadow_in    = shadow_ff;
      powered_in   = powered_ff;
      timer_in     = timer_ff;
      chan_rem_in  = chan_rem_ff;
      do_ctrl_in   = do_ctrl_ff;
      ctrl_val_in  = ctrl_val_ff;
      req_tready   = 1'b0;
      emit         = '0;
      emit.power_on = powered_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in  = req_tuser;
               idx_in   = req_tdata[1:0];
               lvl_in   = req_tdata[9:2];
               want_in  = req_tdata[10];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (mode_ff)
               MODE_LEVEL: begin
                  if (in_use) begin
                     level_in[idx_ff] = lvl_ff;
                     if (blink_ff[idx_ff] && (lvl_ff == 8'd0)) begin
                        blink_in[idx_ff] = 1'b0;
                        if (!others_blink) begin
                           any_blink_in = 1'b0;
                           timer_in     = '0;
                        end
                     end
                     state_in = S_PLAN;
                  end
               end
               MODE_BLINK: begin
                  if (in_use) begin
                     if (blink_ff[idx_ff] && !want_ff) begin
                        blink_in[idx_ff] = 1'b0;
                        if (!others_blink) begin
                           any_blink_in = 1'b0;
                           timer_in     = '0;
                        end
                        state_in = S_PLAN;
                     end else if (lit[idx_ff]) begin
                        blink_in[idx_ff] = 1'b1;
                        if (!any_blink_ff) begin
                           any_blink_in = 1'b1;
                           phase_in     = 1'b1;
                           timer_in     = TICK_W'(1);
                        end
                     end
                  end
               end
               MODE_TICK: begin
                  if (any_blink_ff && (timer_ff != '0)) begin
                     timer_in = timer_ff - TICK_W'(1);
                     if (timer_ff == TICK_W'(1)) begin
                        timer_in = (reload == '0) ? TICK_W'(1) : reload;
                        phase_in = !phase_ff;
                        if (fire_ctl != shadow_ff) begin
                           shadow_in   = fire_ctl;
                           ctrl_val_in = fire_ctl;
                           state_in    = S_CTRL;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
         S_PLAN: begin
            powered_in  = need;
            chan_rem_in = '0;
            do_ctrl_in  = do_ctrl;
            if (pwr_up) begin
               shadow_in = CTRL_DEFAULT;
            end
            if (pwr_down) begin
               cvalid_in = '0;
            end
            if (do_chan) begin
               cached_in[idx_ff] = cur_lvl;
               cvalid_in[idx_ff] = 1'b1;
               chan_rem_in       = cur_mask;
            end
            if (do_ctrl) begin
               shadow_in   = ctl_val;
               ctrl_val_in = ctl_val;
            end
            priority if (pwr_up || pwr_down) begin
               state_in = S_PWR;
            end else if (do_chan) begin
               state_in = S_CHAN;
            end else if (do_ctrl) begin
               state_in = S_CTRL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PWR: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_POWER;
            emit.last  = (chan_rem_ff == '0) && !do_ctrl_ff;
            if (emit_ready) begin
               priority if (chan_rem_ff != '0) begin
                  state_in = S_CHAN;
               end else if (do_ctrl_ff) begin
                  state_in = S_CTRL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CHAN: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_WRITE;
            emit.addr  = chan_addr(chan_k);
            emit.data  = level_ff[idx_ff];
            emit.last  = (rem_after == '0) && !do_ctrl_ff;
            if (emit_ready) begin
               chan_rem_in = rem_after;
               if (rem_after == '0) begin
                  state_in = do_ctrl_ff ? S_CTRL : S_IDLE;
               end
            end
         end
         S_CTRL: begin
            emit.valid = 1'b1;
            emit.kind  = KIND_WRITE;
            emit.addr  = CTRL_REG;
            emit.data  = ctrl_val_ff;
            emit.last  = 1'b1;
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         cached_ff    <= '0;
         cvalid_ff    <= '0;
         blink_ff     <= '0;
         any_blink_ff <= 1'b0;
         phase_ff     <= 1'b0;
         shadow_ff    <= '0;
         powered_ff   <= 1'b0;
         timer_ff     <= '0;
         chan_rem_ff  <= '0;
         do_ctrl_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         cached_ff    <= cached_in;
         cvalid_ff    <= cvalid_in;
         blink_ff     <= blink_in;
         any_blink_ff <= any_blink_in;
         phase_ff     <= phase_in;
         shadow_ff    <= shadow_in;
         powered_ff   <= powered_in;
         timer_ff     <= timer_in;
         chan_rem_ff  <= chan_rem_in;
         do_ctrl_ff   <= do_ctrl_in;
      end
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      lvl_ff      <= lvl_in;
      want_ff     <= want_in;
      ctrl_val_ff <= ctrl_val_in;
   end

endmodule

[rtl/led_group_blink_sequencer.sv]
// a beat passes S_DECODE and S_PLAN before its results, a firing tick S_DECODE and then S_CTRL;
// results leave one per cycle while the output register takes them, up to seven per beat; the
// next beat is taken once the last result reaches the output register, which may still hold it
// reset: synchronous active high; clears led state, power, blink timer and restores masks
// 1, 2, 4, 8, led count 4 and blink times of 500 ticks

module led_group_blink_sequencer
   import lgbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // led_index[1:0], level[9:2], blink_want[10]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // reg_addr[7:0], write_data[15:8], power_on[16]
   output logic        rsp_tuser,   // kind[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type  cfg;
   emit_type emit;
   logic     emit_ready;

   lgbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lgbs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .emit       (emit),
      .emit_ready (emit_ready)
   );

   lgbs_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .emit_ready (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !emit.valid)
      else $error("sequencer emits while taking new beats");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("sequencer ready right after accepting a beat");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit_ready && emit.last) |=> req_tready)
      else $error("sequencer not ready after final result");
`endif

endmodule
